// ----- rtl/sbi_pkg.sv -----
package sbi_pkg;

  localparam int TimerWidth = 16;
  localparam int BlinkWidth = 10;
  localparam int DebWidth   = 8;
  localparam int CfgDataWidth = TimerWidth > BlinkWidth ? TimerWidth : BlinkWidth;

  localparam logic [TimerWidth-1:0] TimeoutReset  = TimerWidth'(2000);
  localparam logic [BlinkWidth-1:0] BlinkReset    = BlinkWidth'(35);
  localparam logic [DebWidth-1:0]   DebounceReset = DebWidth'(10);

  // register indexes on the configuration port
  localparam logic [1:0] CFG_TIMEOUT  = 2'd0;
  localparam logic [1:0] CFG_BLINK    = 2'd1;
  localparam logic [1:0] CFG_DEBOUNCE = 2'd2;

  // output line bit positions
  localparam int LINE_POWER = 4;

  // codes for the four driven lines: bit 0 horn, 1 fault, 2 ready, 3 run
  localparam logic [3:0] DRV_HORN_FAULT = 4'b0011;
  localparam logic [3:0] DRV_FAULT      = 4'b0010;
  localparam logic [3:0] DRV_READY      = 4'b0100;
  localparam logic [3:0] DRV_RUN        = 4'b1000;
  localparam logic [3:0] DRV_READY_RUN  = 4'b1100;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_START_DB,
    MODE_WAIT,
    MODE_BELT_DB,
    MODE_RUN
  } mode_t;

  typedef struct packed {
    logic [TimerWidth-1:0] timeout_ticks;
    logic [BlinkWidth-1:0] blink_half_ticks;
    logic [DebWidth-1:0]   debounce_ticks;
  } cfg_t;

  typedef struct packed {
    mode_t                 mode;
    logic [DebWidth-1:0]   deb_cnt;
    logic [TimerWidth:0]   to_cnt;
    logic                  to_act;
    logic [BlinkWidth:0]   bl_cnt;
    logic                  bl_act;
    logic                  bl_phase;
    logic [4:0]            lines;
  } core_state_t;

endpackage

// ----- rtl/sbi_cfg_regs.sv -----
module sbi_cfg_regs
  import sbi_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [1:0]              cfg_index,
  input  logic [CfgDataWidth-1:0] cfg_data,
  output cfg_t                    cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_ticks    <= TimeoutReset;
      cfg.blink_half_ticks <= BlinkReset;
      cfg.debounce_ticks   <= DebounceReset;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TIMEOUT:  cfg.timeout_ticks    <= cfg_data[TimerWidth-1:0];
        CFG_BLINK:    cfg.blink_half_ticks <= cfg_data[BlinkWidth-1:0];
        CFG_DEBOUNCE: cfg.debounce_ticks   <= cfg_data[DebWidth-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/sbi_core.sv -----
module sbi_core
  import sbi_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic       handbrake_on,
  input  logic       gear_neutral,
  input  logic       seat_level,
  input  logic       belt_level,
  input  cfg_t       cfg,
  output logic [4:0] lines_next
);

  core_state_t st;
  core_state_t st_next;
  logic        hb, neu, seated, belted, start_ok;
  logic        do_run, do_wait, do_idle;

  assign hb       = handbrake_on;
  assign neu      = gear_neutral;
  assign seated   = ~seat_level;
  assign belted   = ~belt_level;
  assign start_ok = hb && neu && seated && !belted;

  assign lines_next = st_next.lines;

  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode     <= MODE_IDLE;
      st.deb_cnt  <= '0;
      st.to_cnt   <= '0;
      st.to_act   <= 1'b0;
      st.bl_cnt   <= '0;
      st.bl_act   <= 1'b0;
      st.bl_phase <= 1'b0;
      st.lines    <= '0;
    end else if (step) begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next = st;
    do_run  = 1'b0;
    do_wait = 1'b0;
    do_idle = 1'b0;

    // grace timeout advances first; expiry drops to idle
    if (st_next.to_act) begin
      st_next.to_cnt = st_next.to_cnt + 1'b1;
      if (st_next.to_cnt > {1'b0, cfg.timeout_ticks}) begin
        st_next.to_act = 1'b0;
        st_next.to_cnt = '0;
        st_next.mode   = MODE_IDLE;
      end
    end

    if (st_next.bl_act) begin
      st_next.bl_cnt = st_next.bl_cnt + 1'b1;
      if (st_next.bl_cnt > {1'b0, cfg.blink_half_ticks}) begin
        st_next.bl_cnt = '0;
        st_next.lines[LINE_POWER] = st_next.bl_phase;
        st_next.bl_phase = ~st_next.bl_phase;
      end
    end

    case (st_next.mode)
      MODE_START_DB: begin
        if (st_next.deb_cnt < cfg.debounce_ticks) begin
          st_next.deb_cnt = st_next.deb_cnt + 1'b1;
        end else if (start_ok) begin
          do_wait = 1'b1;
        end else begin
          do_idle = 1'b1;
        end
      end
      MODE_WAIT: do_wait = 1'b1;
      MODE_BELT_DB: begin
        if (st_next.deb_cnt < cfg.debounce_ticks) begin
          st_next.deb_cnt = st_next.deb_cnt + 1'b1;
        end else if (hb && neu && seated && belted) begin
          do_run = 1'b1;
        end else begin
          do_wait = 1'b1;
        end
      end
      MODE_RUN: do_run = 1'b1;
      default:  do_idle = 1'b1;
    endcase

    // run may fall to wait, and wait to idle, within the same tick
    if (do_run) begin
      st_next.mode = MODE_RUN;
      if (seated && belted) begin
        st_next.lines[3:0] = DRV_RUN;
        st_next.bl_act = 1'b0;
        st_next.bl_cnt = '0;
        st_next.lines[LINE_POWER] = 1'b1;
        st_next.to_act = 1'b0;
        st_next.to_cnt = '0;
      end else if (hb && neu) begin
        st_next.to_act = 1'b0;
        st_next.to_cnt = '0;
        do_wait = 1'b1;
      end else begin
        st_next.lines[3:0] = DRV_READY_RUN;
        if (!st_next.bl_act) begin
          st_next.bl_act = 1'b1;
          st_next.bl_cnt = '0;
        end
        if (!st_next.to_act) begin
          st_next.to_act = 1'b1;
          st_next.to_cnt = '0;
        end
      end
    end

    if (do_wait) begin
      if (!(hb && neu && seated)) begin
        do_idle = 1'b1;
      end else begin
        st_next.mode = MODE_WAIT;
        st_next.lines[3:0] = DRV_READY;
        st_next.bl_act = 1'b0;
        st_next.bl_cnt = '0;
        st_next.lines[LINE_POWER] = 1'b1;
        if (belted) begin
          st_next.mode    = MODE_BELT_DB;
          st_next.deb_cnt = '0;
        end
      end
    end

    if (do_idle) begin
      st_next.mode = MODE_IDLE;
      if (start_ok) begin
        st_next.mode    = MODE_START_DB;
        st_next.deb_cnt = '0;
      end else if (!hb || !neu) begin
        st_next.lines[3:0] = DRV_HORN_FAULT;
        if (!st_next.bl_act) begin
          st_next.bl_act = 1'b1;
          st_next.bl_cnt = '0;
        end
      end else begin
        st_next.lines[3:0] = DRV_FAULT;
        st_next.bl_act = 1'b0;
        st_next.bl_cnt = '0;
        st_next.lines[LINE_POWER] = 1'b1;
      end
    end
  end

endmodule

// ----- rtl/sbi_out_queue.sv -----
module sbi_out_queue
  import sbi_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [4:0] push_data,
  output logic       has_room,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata
);

  logic [4:0] head, tail;
  logic [1:0] count;
  logic       pop;

  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = (count != 2'd0);
  assign has_room = (count != 2'd2);
  assign m_tdata  = {3'b000, head};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10: count <= count + 2'd1;
        2'b01: count <= count - 2'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (count == 2'd0) begin
          head <= push_data;
        end else begin
          tail <= push_data;
        end
      end
      2'b01: head <= tail;
      2'b11: begin
        if (count == 2'd1) begin
          head <= push_data;
        end else begin
          head <= tail;
          tail <= push_data;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/seat_belt_interlock_fsm.sv -----
// Seat-belt interlock controller, one sensor tick per input transfer.
// The result for a tick is registered in the result buffer at its transfer.
// Throughput: one tick per cycle while the buffer has room; a two-entry result
// buffer keeps input open while one result waits on the output side, and holds it once full.
// Reset (rst, synchronous): mode idle, counters and output lines cleared,
// registers back to timeout 2000, blink 35, debounce 10.
module seat_belt_interlock_fsm
  import sbi_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [7:0]              s_tdata,   // handbrake_on, gear_neutral, seat_level, belt_level
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [7:0]              m_tdata,   // horn, led_fault, led_ready, led_run, power_led
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [1:0]              cfg_index,
  input  logic [CfgDataWidth-1:0] cfg_data
);

  cfg_t       cfg;
  logic       step;
  logic       has_room;
  logic [4:0] lines_next;

  assign s_tready = has_room;
  assign step     = s_tvalid && has_room;

  sbi_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sbi_core u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .handbrake_on (s_tdata[0]),
    .gear_neutral (s_tdata[1]),
    .seat_level   (s_tdata[2]),
    .belt_level   (s_tdata[3]),
    .cfg          (cfg),
    .lines_next   (lines_next)
  );

  sbi_out_queue u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (step),
    .push_data (lines_next),
    .has_room  (has_room),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

// ----- rtl/sbi_checker.sv -----
module sbi_checker
  import sbi_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // every accepted tick shows a result on the next cycle
  a_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("no result after input transfer");

  // horn only sounds alongside the fault LED
  a_horn: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[1])
    else $error("horn without fault LED");

  // run LED and fault LED are exclusive
  a_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[1] && m_tdata[3]))
    else $error("run and fault LEDs together");

endmodule

bind seat_belt_interlock_fsm sbi_checker u_sbi_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- tb/seat_belt_interlock_fsm_tb.sv -----
module seat_belt_interlock_fsm_tb;
  import sbi_pkg::*;

  // index beyond the three registers; writes to it must be dropped
  localparam logic [1:0] CFG_SPARE = 2'd3;

  // sensor nibble as packed on s_tdata: bit 0 handbrake, 1 neutral, 2 seat, 3 belt
  localparam logic [3:0] SENS_ARMED  = 4'b1011;  // brake, neutral, seated, unbelted
  localparam logic [3:0] SENS_BELTED = 4'b0011;  // brake, neutral, seated, belted

  logic                    clk       = 1'b0;
  logic                    rst       = 1'b1;
  logic                    s_tvalid  = 1'b0;
  logic                    s_tready;
  logic [7:0]              s_tdata   = '0;
  logic                    m_tvalid;
  logic                    m_tready  = 1'b1;
  logic [7:0]              m_tdata;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [1:0]              cfg_index = '0;
  logic [CfgDataWidth-1:0] cfg_data  = '0;

  seat_belt_interlock_fsm dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // interlock predictor state
  logic [TimerWidth-1:0] grace_limit  = TimeoutReset;
  logic [BlinkWidth-1:0] flash_half   = BlinkReset;
  logic [DebWidth-1:0]   settle_limit = DebounceReset;
  mode_t                 phase_mode   = MODE_IDLE;
  logic [DebWidth-1:0]   settle_cnt   = '0;
  logic [TimerWidth:0]   grace_cnt    = '0;
  logic                  grace_on     = 1'b0;
  logic [BlinkWidth:0]   flash_cnt    = '0;
  logic                  flash_on     = 1'b0;
  logic                  flash_phase  = 1'b0;
  logic [4:0]            lamp         = '0;
  logic                  hb, neu, seated, belted;

  logic [4:0] expected_lines [$];
  int         mismatches      = 0;
  int         ticks_sent      = 0;
  bit         idle_on         = 1'b1;
  int         sink_stall_left = 0;
  string      line_name [5]   = '{"horn", "led_fault", "led_ready", "led_run", "power_led"};

  function automatic void show_lines(logic [3:0] drv);
    lamp = {lamp[LINE_POWER], drv};
  endfunction

  function automatic void power_hold();
    flash_on = 1'b0;
    flash_cnt = '0;
    lamp[LINE_POWER] = 1'b1;
  endfunction

  function automatic void flash_begin();
    if (!flash_on) begin
      flash_on = 1'b1;
      flash_cnt = '0;
    end
  endfunction

  function automatic void grace_clear();
    grace_on = 1'b0;
    grace_cnt = '0;
  endfunction

  function automatic void idle_eval();
    phase_mode = MODE_IDLE;
    if (hb && neu && seated && !belted) begin
      phase_mode = MODE_START_DB;
      settle_cnt = '0;
    end else if (!hb || !neu) begin
      show_lines(DRV_HORN_FAULT);
      flash_begin();
    end else begin
      show_lines(DRV_FAULT);
      power_hold();
    end
  endfunction

  function automatic void wait_eval();
    if (!(hb && neu && seated)) begin
      idle_eval();
      return;
    end
    phase_mode = MODE_WAIT;
    show_lines(DRV_READY);
    power_hold();
    if (belted) begin
      phase_mode = MODE_BELT_DB;
      settle_cnt = '0;
    end
  endfunction

  function automatic void run_eval();
    phase_mode = MODE_RUN;
    if (seated && belted) begin
      show_lines(DRV_RUN);
      power_hold();
      grace_clear();
    end else if (hb && neu) begin
      // stop the grace timer before falling back, so it never outlives run
      grace_clear();
      wait_eval();
    end else begin
      show_lines(DRV_READY_RUN);
      flash_begin();
      if (!grace_on) begin
        grace_on = 1'b1;
        grace_cnt = '0;
      end
    end
  endfunction

  function automatic logic [4:0] advance_interlock(logic [3:0] sensors);
    hb     = sensors[0];
    neu    = sensors[1];
    seated = !sensors[2];
    belted = !sensors[3];
    if (grace_on) begin
      grace_cnt++;
      if (grace_cnt > {1'b0, grace_limit}) begin
        grace_clear();
        phase_mode = MODE_IDLE;
      end
    end
    if (flash_on) begin
      flash_cnt++;
      if (flash_cnt > {1'b0, flash_half}) begin
        flash_cnt = '0;
        lamp[LINE_POWER] = flash_phase;
        flash_phase = !flash_phase;
      end
    end
    case (phase_mode)
      MODE_START_DB: begin
        if (settle_cnt < settle_limit) settle_cnt++;
        else if (hb && neu && seated && !belted) wait_eval();
        else idle_eval();
      end
      MODE_WAIT: wait_eval();
      MODE_BELT_DB: begin
        if (settle_cnt < settle_limit) settle_cnt++;
        else if (hb && neu && seated && belted) run_eval();
        else wait_eval();
      end
      MODE_RUN: run_eval();
      default: idle_eval();
    endcase
    return lamp;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t: %s", $realtime, what);
  endtask

  // result checker
  always @(posedge clk) begin
    logic [4:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_lines.size() == 0) begin
        report_mismatch($sformatf("result 0x%02h with no tick pending", m_tdata));
      end else begin
        want = expected_lines.pop_front();
        for (int b = 0; b < 5; b++)
          if (m_tdata[b] !== want[b])
            report_mismatch($sformatf("%s: expected %0b, got %0b",
                                      line_name[b], want[b], m_tdata[b]));
      end
    end
  end

  // output back-pressure in random bursts
  always @(negedge clk) begin
    if (sink_stall_left != 0) begin
      sink_stall_left <= sink_stall_left - 1;
      m_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      sink_stall_left <= $urandom_range(0, 11);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // entered and left at a falling edge
  task automatic send_tick(input logic [3:0] sensors);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0000, sensors};
    do @(posedge clk); while (!s_tready);
    expected_lines.push_back(advance_interlock(sensors));
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [CfgDataWidth-1:0] value,
                                input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_TIMEOUT:  grace_limit  = value[TimerWidth-1:0];
      CFG_BLINK:    flash_half   = value[BlinkWidth-1:0];
      CFG_DEBOUNCE: settle_limit = value[DebWidth-1:0];
      default: ;
    endcase
    @(negedge clk);
    if (last) cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_lines.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // blink and debounce registers are written with random bits above each field's width
  task automatic write_settings(input int grace, input int half, input int settle);
    logic [CfgDataWidth-1:0] word;
    write_register(CFG_TIMEOUT, CfgDataWidth'(grace), 1'b0);
    word = CfgDataWidth'($urandom);
    word[BlinkWidth-1:0] = BlinkWidth'(half);
    write_register(CFG_BLINK, word, 1'b0);
    word = CfgDataWidth'($urandom);
    word[DebWidth-1:0] = DebWidth'(settle);
    write_register(CFG_DEBOUNCE, word, 1'b1);
  endtask

  task automatic send_run(input logic [3:0] pattern, input int n, input bit jitter);
    for (int i = 0; i < n; i++) begin
      if (jitter && $urandom_range(0, 15) == 0) send_tick(4'($urandom));
      else send_tick(pattern);
    end
  endtask

  // off the seat or unbelted, with handbrake or neutral released
  function automatic logic [3:0] random_unsafe_leave();
    logic [3:0] v;
    do v = 4'($urandom); while (!(v[3] | v[2]) || (v[0] & v[1]));
    return v;
  endfunction

  task automatic drive_journey();
    int leave_max;
    repeat ($urandom_range(0, 3)) send_tick(4'($urandom));
    send_run(SENS_ARMED, int'(settle_limit) + $urandom_range(1, 4), 1'b1);
    send_run(SENS_ARMED, $urandom_range(0, 3), 1'b0);
    send_run(SENS_BELTED, int'(settle_limit) + $urandom_range(1, 4), 1'b1);
    send_run(SENS_BELTED, $urandom_range(0, 6), 1'b0);
    case ($urandom_range(0, 3))
      0, 1: begin
        leave_max = int'(grace_limit) + 3;
        if (leave_max > 400) leave_max = 400;
        repeat ($urandom_range(1, leave_max)) send_tick(random_unsafe_leave());
        send_run(SENS_BELTED, $urandom_range(0, 3), 1'b0);
      end
      2: begin
        // leave with brake and neutral both set: back to waiting for the belt, or to idle when off the seat
        send_tick({1'b1, 1'($urandom), 2'b11});
        send_run(SENS_ARMED, $urandom_range(0, 4), 1'b1);
      end
      default: ;
    endcase
  endtask

  task automatic run_journeys(input int n);
    int stop_at;
    stop_at = ticks_sent + n;
    while (ticks_sent < stop_at) begin
      if ($urandom_range(0, 9) < 7) drive_journey();
      else repeat ($urandom_range(1, 8)) send_tick(4'($urandom));
    end
  endtask

  task automatic test_reset_defaults();
    send_tick(4'b0000);
    send_run(SENS_ARMED, 2, 1'b0);
    wait_drained();
  endtask

  task automatic test_register_maxima();
    write_register(CFG_TIMEOUT, '1, 1'b0);
    write_register(CFG_BLINK, '1, 1'b0);
    write_register(CFG_DEBOUNCE, '1, 1'b0);
    write_register(CFG_SPARE, CfgDataWidth'($urandom), 1'b1);
    send_tick(4'b1111);
    send_tick(4'b0000);
    send_tick(SENS_BELTED);
    wait_drained();
  endtask

  // zero registers: instant debounce, timeout one tick after start, blink every tick
  task automatic test_zero_registers();
    write_register(CFG_TIMEOUT, '0, 1'b0);
    write_register(CFG_BLINK, '0, 1'b0);
    write_register(CFG_DEBOUNCE, '0, 1'b1);
    send_run(4'b1100, 3, 1'b0);
    send_tick(4'b1111);
    send_run(SENS_ARMED, 2, 1'b0);
    send_run(SENS_BELTED, 3, 1'b0);
    send_run(4'b0110, 2, 1'b0);
    send_run(SENS_ARMED, 2, 1'b0);
    send_run(SENS_BELTED, 2, 1'b0);
    send_tick(SENS_ARMED);
    send_tick(4'b0111);
    // resample fails: start debounce back to idle, belt debounce back to wait
    send_tick(SENS_ARMED);
    send_tick(4'b1111);
    send_run(SENS_ARMED, 2, 1'b0);
    send_tick(SENS_BELTED);
    send_tick(SENS_ARMED);
    wait_drained();
  endtask

  task automatic test_random_settings();
    for (int p = 0; p < 5; p++) begin
      write_settings(p == 0 ? 300 : $urandom_range(0, 40),
                     p == 1 ? 0 : $urandom_range(0, 8),
                     p == 3 ? 12 : $urandom_range(0, 5));
      run_journeys(300);
      wait_drained();
    end
  endtask

  task automatic test_quiet_tail();
    idle_on = 1'b0;
    write_settings($urandom_range(0, 30), $urandom_range(0, 6), $urandom_range(0, 4));
    run_journeys(150);
    wait_drained();
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_register_maxima();
    test_zero_registers();
    test_random_settings();
    test_quiet_tail();
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/sbi_pkg.sv
rtl/sbi_cfg_regs.sv
rtl/sbi_core.sv
rtl/sbi_out_queue.sv
rtl/seat_belt_interlock_fsm.sv
rtl/sbi_checker.sv
tb/seat_belt_interlock_fsm_tb.sv
